// ===== hdl/mtwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mtwm_pkg: shared types and constants for the median / weighted-mean filter
// Payload structs, per-channel vectors and the counter limits of the block.
// ----------------------------------------------------------------------------
package mtwm_pkg;

  localparam int NUM_CHAN   = 3;
  localparam int CHAN_W     = 8;
  // Only the five smallest values of a window are kept: the median of nine
  // is the fifth smallest.
  localparam int SORT_CELLS = 5;
  localparam int MED_CELL   = SORT_CELLS - 1;
  localparam int ROW_CELLS  = 5;
  localparam int Q_W        = 6;   // x/5 of an 8-bit value, at most 51
  localparam int SUM_W      = 7;   // three x/10 terms, at most 75
  localparam int CENT_W     = 5;   // 2x/10 - x/10, at most 26

  localparam logic [3:0] PIX_LAST   = 4'd8;
  localparam logic [3:0] WIN_LAST   = 4'd14;
  localparam logic [3:0] EMIT_FIRST = 4'd12;
  localparam logic [3:0] COL1_START = 4'd5;
  localparam logic [3:0] COL2_START = 4'd10;

  typedef enum logic [1:0] {
    COL_FIRST,
    COL_CENTER,
    COL_LAST
  } col_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan_high;
    logic [CHAN_W-1:0] chan_mid;
    logic [CHAN_W-1:0] chan_low;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] mean_chan_low;
    logic [CHAN_W-1:0] mean_chan_mid;
    logic [CHAN_W-1:0] mean_chan_high;
  } mean_t;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan3_t;
  typedef logic [NUM_CHAN-1:0][Q_W-1:0]    q3_t;
  typedef logic [NUM_CHAN-1:0][SUM_W-1:0]  sum3_t;
  typedef logic [NUM_CHAN-1:0][CENT_W-1:0] cent3_t;
  typedef logic [NUM_CHAN-1:0]             chmask_t;

endpackage

// ===== hdl/mtwm_sort_cell.sv =====
// ----------------------------------------------------------------------------
// mtwm_sort_cell: one position of the insertion-sort chain
// Holds one sorted value per channel; on insert keeps it, takes the new
// value or takes the left neighbor's value.
// ----------------------------------------------------------------------------
module mtwm_sort_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               ins,
  input  logic               clear,
  input  mtwm_pkg::chan3_t   x,
  input  mtwm_pkg::chan3_t   left_val,
  input  mtwm_pkg::chmask_t  left_gt,
  input  logic               left_valid,
  output mtwm_pkg::chan3_t   val,
  output logic               valid,
  output mtwm_pkg::chmask_t  gt,
  output mtwm_pkg::chan3_t   val_next
);

  // An empty cell counts as larger than anything.
  always_comb begin
    for (int c = 0; c < mtwm_pkg::NUM_CHAN; c++) begin
      gt[c] = !valid || (val[c] > x[c]);
      if (!gt[c]) begin
        val_next[c] = val[c];
      end else if (left_gt[c]) begin
        val_next[c] = left_val[c];
      end else begin
        val_next[c] = x[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins) begin
      valid <= clear ? 1'b0 : (valid | left_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      val <= val_next;
    end
  end

endmodule

// ===== hdl/mtwm_row_cell.sv =====
// ----------------------------------------------------------------------------
// mtwm_row_cell: one row of the median grid ring
// Holds the running x/10 sum of a grid row and its center correction;
// takes the neighbor's row on every shift, folding in a new median if told.
// ----------------------------------------------------------------------------
module mtwm_row_cell (
  input  logic              clk,
  input  logic              shift,
  input  logic              apply,
  input  mtwm_pkg::q3_t     q2,
  input  mtwm_pkg::col_t    col,
  input  mtwm_pkg::sum3_t   nb_sum,
  input  mtwm_pkg::cent3_t  nb_cent,
  output mtwm_pkg::sum3_t   sum,
  output mtwm_pkg::cent3_t  cent
);

  logic [mtwm_pkg::NUM_CHAN-1:0][mtwm_pkg::Q_W-1:0] q_half;
  logic [mtwm_pkg::NUM_CHAN-1:0][mtwm_pkg::Q_W-1:0] q_extra;
  mtwm_pkg::sum3_t  applied_sum;
  mtwm_pkg::cent3_t applied_cent;

  // x/10 = (x/5)/2, and the center's extra share 2x/10 - x/10.
  always_comb begin
    for (int c = 0; c < mtwm_pkg::NUM_CHAN; c++) begin
      q_half[c]  = q2[c] >> 1;
      q_extra[c] = q2[c] - q_half[c];
      if (col == mtwm_pkg::COL_FIRST) begin
        applied_sum[c] = mtwm_pkg::SUM_W'(q_half[c]);
      end else begin
        applied_sum[c] = nb_sum[c] + mtwm_pkg::SUM_W'(q_half[c]);
      end
      if (col == mtwm_pkg::COL_CENTER) begin
        applied_cent[c] = q_extra[c][mtwm_pkg::CENT_W-1:0];
      end else begin
        applied_cent[c] = nb_cent[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      sum  <= apply ? applied_sum  : nb_sum;
      cent <= apply ? applied_cent : nb_cent;
    end
  end

endmodule

// ===== hdl/median_then_weighted_mean_rgb.sv =====
// ----------------------------------------------------------------------------
// median_then_weighted_mean_rgb: 3x3 median filter with weighted mean
// Per-channel median of nine-pixel windows, then a 3x3 weighted mean over a
// rotating five-row grid of those medians.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock and never stalls except in one
// case: the ninth pixel of window 12, 13 or 14 waits while an earlier mean is
// still held by a stalled output. Each pixel is inserted into a five-cell
// insertion-sort chain per channel in the cycle it arrives, so the median of
// a window is known as its ninth pixel is taken. The ninth pixel of windows
// 12, 13 and 14 of every cycle of fifteen windows makes a mean request, via
// stages A, B, C and the output register; every other window produces no
// output. The weighted mean uses x/10 for each grid entry and 2x/10 for the
// center, each truncated, and never exceeds 251. Channel zero of the pixel
// maps to mean_chan_low, which sits at bits 23:16 of the mean word.
// ----------------------------------------------------------------------------
module median_then_weighted_mean_rgb (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  mtwm_pkg::pixel_t pixel,
  output logic             mean_valid,
  input  logic             mean_stall,
  output mtwm_pkg::mean_t  mean
);

  localparam int SC = mtwm_pkg::SORT_CELLS;
  localparam int RC = mtwm_pkg::ROW_CELLS;
  localparam int NUM_PROD = mtwm_pkg::NUM_CHAN;
  localparam logic [15:0] RECIP = 16'd205;   // x*205 >> 10 == x/5 for 8 bits

  // Window position counters.
  logic [3:0] pix_cnt;
  logic [3:0] win_cnt;
  logic       last_pix;
  logic       emit_win;
  logic       accept;
  mtwm_pkg::col_t win_col;

  // Sort chain.
  mtwm_pkg::chan3_t  x;
  mtwm_pkg::chan3_t  s_val      [SC];
  mtwm_pkg::chan3_t  s_next     [SC];
  mtwm_pkg::chan3_t  s_left_val [SC];
  mtwm_pkg::chmask_t s_gt       [SC];
  mtwm_pkg::chmask_t s_left_gt  [SC];
  logic              s_valid    [SC];
  logic              s_left_vld [SC];

  // Pipeline after the median.
  logic             a_valid;
  logic             a_emit;
  mtwm_pkg::col_t   a_col;
  mtwm_pkg::chan3_t med;
  logic             b_valid;
  logic             b_emit;
  mtwm_pkg::col_t   b_col;
  mtwm_pkg::q3_t    q2;
  logic             c_emit;
  logic [NUM_PROD-1:0][15:0] prod;

  // Row ring.
  mtwm_pkg::sum3_t  r_sum  [RC];
  mtwm_pkg::cent3_t r_cent [RC];
  mtwm_pkg::sum3_t  r_nb_sum  [RC];
  mtwm_pkg::cent3_t r_nb_cent [RC];

  logic [mtwm_pkg::NUM_CHAN-1:0][8:0] total;

  assign x[0] = pixel.chan_low;
  assign x[1] = pixel.chan_mid;
  assign x[2] = pixel.chan_high;

  assign last_pix = (pix_cnt >= mtwm_pkg::PIX_LAST);
  assign emit_win = (win_cnt >= mtwm_pkg::EMIT_FIRST);

  // Hold the result-making pixel only while a stalled mean still waits.
  assign pixel_stall = mean_valid && mean_stall && last_pix && emit_win;
  assign accept      = pixel_valid && !pixel_stall;

  always_comb begin
    if (win_cnt < mtwm_pkg::COL1_START) begin
      win_col = mtwm_pkg::COL_FIRST;
    end else if (win_cnt < mtwm_pkg::COL2_START) begin
      win_col = mtwm_pkg::COL_CENTER;
    end else begin
      win_col = mtwm_pkg::COL_LAST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_cnt <= '0;
      win_cnt <= '0;
    end else if (accept) begin
      if (last_pix) begin
        pix_cnt <= '0;
        win_cnt <= (win_cnt >= mtwm_pkg::WIN_LAST) ? 4'd0 : win_cnt + 4'd1;
      end else begin
        pix_cnt <= pix_cnt + 4'd1;
      end
    end
  end

  // Sort chain: cell 0 always takes the new value when it is the smallest.
  for (genvar i = 0; i < SC; i++) begin : g_sort
    if (i == 0) begin : g_head
      assign s_left_val[i] = x;
      assign s_left_gt[i]  = '0;
      assign s_left_vld[i] = 1'b1;
    end else begin : g_body
      assign s_left_val[i] = s_val[i-1];
      assign s_left_gt[i]  = s_gt[i-1];
      assign s_left_vld[i] = s_valid[i-1];
    end

    mtwm_sort_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ins        (accept),
      .clear      (last_pix),
      .x          (x),
      .left_val   (s_left_val[i]),
      .left_gt    (s_left_gt[i]),
      .left_valid (s_left_vld[i]),
      .val        (s_val[i]),
      .valid      (s_valid[i]),
      .gt         (s_gt[i]),
      .val_next   (s_next[i])
    );
  end

  // Stage A: capture the median as the window's ninth pixel goes in.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept && last_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_pix) begin
      med    <= s_next[mtwm_pkg::MED_CELL];
      a_emit <= emit_win;
      a_col  <= win_col;
    end
  end

  // Stage B: x/5 by reciprocal multiply.
  always_comb begin
    for (int c = 0; c < NUM_PROD; c++) begin
      prod[c] = 16'(med[c]) * RECIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      for (int c = 0; c < NUM_PROD; c++) begin
        q2[c] <= prod[c][15:10];
      end
      b_emit <= a_emit;
      b_col  <= a_col;
    end
  end

  // Stage C: rotate the ring one row; the current row re-enters at the tail
  // with the new median folded in, so the head is always the row to update.
  for (genvar i = 0; i < RC; i++) begin : g_row
    if (i == RC - 1) begin : g_tail
      assign r_nb_sum[i]  = r_sum[0];
      assign r_nb_cent[i] = r_cent[0];
    end else begin : g_body
      assign r_nb_sum[i]  = r_sum[i+1];
      assign r_nb_cent[i] = r_cent[i+1];
    end

    mtwm_row_cell u_row (
      .clk     (clk),
      .shift   (b_valid),
      .apply   (i == RC - 1),
      .q2      (q2),
      .col     (b_col),
      .nb_sum  (r_nb_sum[i]),
      .nb_cent (r_nb_cent[i]),
      .sum     (r_sum[i]),
      .cent    (r_cent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_emit <= 1'b0;
    end else begin
      c_emit <= b_valid && b_emit;
    end
  end

  // Stage D: the newest row sits at the tail, the two before it just ahead;
  // the middle one of the three carries the center correction.
  always_comb begin
    for (int c = 0; c < mtwm_pkg::NUM_CHAN; c++) begin
      total[c] = 9'(r_sum[RC-1][c]) + 9'(r_sum[RC-2][c]) + 9'(r_sum[RC-3][c])
               + 9'(r_cent[RC-2][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (c_emit) begin
      mean_valid <= 1'b1;
    end else if (!mean_stall) begin
      mean_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_emit) begin
      mean.mean_chan_low  <= total[0][7:0];
      mean.mean_chan_mid  <= total[1][7:0];
      mean.mean_chan_high <= total[2][7:0];
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for median_then_weighted_mean_rgb
// Drives windows of nine pixels and predicts every mean request from a
// per-channel median and a 3x3 weighted mean over a five-row grid. A directed
// table comes first, then random windows under four idle/stall phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int WIN_PIX          = 9;
  localparam int GRID_ROWS        = 5;
  localparam int GRID_COLS        = 3;
  localparam int GRID_CELLS       = 15;
  localparam int EMIT_FROM        = 13;   // window count after which a mean goes out
  localparam int CENTER_TAP       = 4;
  localparam int QUIET_LIMIT      = 1000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int CYCLES_PER_PHASE = 2;
  localparam int NUM_PHASES       = 4;

  // Nine distinct channel values; rotated per window for the low and high
  // channels, at a fixed offset for the mid channel.
  localparam logic [0:8][7:0] SCATTER = {8'd200, 8'd10, 8'd90, 8'd255, 8'd0,
                                         8'd130, 8'd60, 8'd170, 8'd40};

  // Idle and stall odds of each phase, in percent: none, sparse sender,
  // slow receiver, a little of both.
  localparam logic [0:3][7:0] IDLE_PCT  = {8'd0, 8'd72, 8'd0,  8'd15};
  localparam logic [0:3][7:0] STALL_PCT = {8'd0, 8'd0,  8'd72, 8'd15};

  typedef enum logic [2:0] {
    WIN_FLAT,
    WIN_SCATTER,
    WIN_NOISE,
    WIN_CLUSTER,
    WIN_RAILS
  } win_kind_t;

  // One directed row: a run of windows of one shape, with the mean typed in
  // where it is plain from the pixel values.
  typedef struct packed {
    win_kind_t        kind;
    mtwm_pkg::pixel_t base;
    logic [4:0]       n_win;
    logic             typed;
    mtwm_pkg::mean_t  want;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             pixel_valid;
  logic             pixel_stall;
  mtwm_pkg::pixel_t pixel;
  logic             mean_valid;
  logic             mean_stall;
  mtwm_pkg::mean_t  mean;

  // Filter state as the block should hold it.
  mtwm_pkg::chan3_t win_buf [WIN_PIX];
  mtwm_pkg::chan3_t grid_med [GRID_CELLS];
  int unsigned      pix_in_win;
  int unsigned      win_in_cycle;

  mtwm_pkg::mean_t  means_due [$];
  int unsigned      n_errors;
  int unsigned      idle_pct;
  int unsigned      stall_pct;
  int unsigned      quiet_cycles;
  bit               typed_on;
  mtwm_pkg::mean_t  typed_mean;
  dir_row_t         dir_tab [6];

  median_then_weighted_mean_rgb uut (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .mean_valid (mean_valid),
    .mean_stall (mean_stall),
    .mean       (mean)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Fifth smallest of the nine values of one channel in the window.
  function automatic logic [7:0] window_median(int c);
    logic [7:0] v [WIN_PIX];
    logic [7:0] t;
    for (int i = 0; i < WIN_PIX; i++) v[i] = win_buf[i][c];
    for (int i = 1; i < WIN_PIX; i++) begin
      for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
        t      = v[j];
        v[j]   = v[j-1];
        v[j-1] = t;
      end
    end
    return v[CENTER_TAP];
  endfunction

  // Weighted mean over three grid rows starting at first_row, all columns.
  // Each term is truncated on its own, so the sum never passes 251.
  function automatic logic [7:0] grid_mean(int first_row, int c);
    int unsigned acc;
    int unsigned x;
    acc = 0;
    for (int k = 0; k < WIN_PIX; k++) begin
      x = 32'(grid_med[first_row * GRID_COLS + k][c]);
      acc += (k == CENTER_TAP) ? (2 * x) / 10 : x / 10;
    end
    return acc[7:0];
  endfunction

  // Advance the filter by one pixel; return 1 with the mean when one is due.
  function automatic bit filter_step(mtwm_pkg::pixel_t p, output mtwm_pkg::mean_t m);
    mtwm_pkg::chan3_t px;
    mtwm_pkg::chan3_t med;
    int               first_row;
    px = {p.chan_high, p.chan_mid, p.chan_low};
    m  = '0;
    if (pix_in_win < WIN_PIX - 1) begin
      win_buf[pix_in_win] = px;
      pix_in_win++;
      return 1'b0;
    end
    win_buf[WIN_PIX-1] = px;
    pix_in_win = 0;
    for (int c = 0; c < mtwm_pkg::NUM_CHAN; c++) med[c] = window_median(c);
    // Window k fills row k mod 5 of column k div 5.
    grid_med[(win_in_cycle % GRID_ROWS) * GRID_COLS + win_in_cycle / GRID_ROWS] = med;
    win_in_cycle++;
    if (win_in_cycle < EMIT_FROM) return 1'b0;
    first_row        = win_in_cycle - EMIT_FROM;
    m.mean_chan_low  = grid_mean(first_row, 0);
    m.mean_chan_mid  = grid_mean(first_row, 1);
    m.mean_chan_high = grid_mean(first_row, 2);
    if (win_in_cycle == GRID_CELLS) win_in_cycle = 0;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Pixel k of window w for a given window shape.
  function automatic mtwm_pkg::pixel_t make_pixel(win_kind_t kind, mtwm_pkg::pixel_t base,
                                                  int w, int k);
    mtwm_pkg::pixel_t p;
    logic [31:0]      r;
    p = base;
    case (kind)
      WIN_FLAT: begin
        p = base;
      end
      WIN_SCATTER: begin
        p.chan_low  = base.chan_low  + SCATTER[(k + w) % WIN_PIX];
        p.chan_mid  = base.chan_mid  + SCATTER[(k + 3) % WIN_PIX];
        p.chan_high = base.chan_high + SCATTER[(WIN_PIX - 1 - k + w) % WIN_PIX];
      end
      WIN_CLUSTER: begin
        // Values close together, so medians hinge on small differences.
        r = $urandom_range(15);
        p.chan_low  = base.chan_low + r[7:0];
        r = $urandom_range(15);
        p.chan_mid  = base.chan_mid + r[7:0];
        r = $urandom_range(15);
        p.chan_high = base.chan_high + r[7:0];
      end
      WIN_RAILS: begin
        p.chan_low  = $urandom_range(1) ? 8'hFF : 8'h00;
        p.chan_mid  = $urandom_range(1) ? 8'hFF : 8'h00;
        p.chan_high = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: begin
        r = $urandom;
        p = r[23:0];
      end
    endcase
    return p;
  endfunction

  // Offer one pixel request, hold it through stalls, then predict it.
  task automatic send_pixel(mtwm_pkg::pixel_t p);
    mtwm_pkg::mean_t m;
    while ($urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (pixel_stall);
    if (filter_step(p, m)) means_due.push_back(typed_on ? typed_mean : m);
  endtask

  task automatic send_window(win_kind_t kind, mtwm_pkg::pixel_t base, int w);
    for (int k = 0; k < WIN_PIX; k++) send_pixel(make_pixel(kind, base, w, k));
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("ERROR %0t: %s: got %0d, want %0d", $time, what, got, want);
    n_errors++;
  endtask

  // Compare an accepted mean request against the oldest one predicted.
  task automatic check_mean(mtwm_pkg::mean_t got);
    mtwm_pkg::mean_t want;
    if (means_due.size() == 0) begin
      report_mismatch("mean request with none pending", got, '0);
      return;
    end
    want = means_due.pop_front();
    if (got.mean_chan_low !== want.mean_chan_low)
      report_mismatch("mean_chan_low", 24'(got.mean_chan_low), 24'(want.mean_chan_low));
    if (got.mean_chan_mid !== want.mean_chan_mid)
      report_mismatch("mean_chan_mid", 24'(got.mean_chan_mid), 24'(want.mean_chan_mid));
    if (got.mean_chan_high !== want.mean_chan_high)
      report_mismatch("mean_chan_high", 24'(got.mean_chan_high), 24'(want.mean_chan_high));
  endtask

  // Receiver: stall at the phase's odds, check every accepted mean, and end
  // the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      mean_stall   <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      mean_stall <= ($urandom_range(99) < stall_pct);
      if (mean_valid && !mean_stall) check_mean(mean);
      if ((pixel_valid && !pixel_stall) || (mean_valid && !mean_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("median_then_weighted_mean_rgb: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0]      r;
    mtwm_pkg::pixel_t base;
    win_kind_t        kind;

    rst          = 1'b1;
    pixel_valid  = 1'b0;
    pixel        = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    typed_on     = 1'b0;
    typed_mean   = '0;
    n_errors     = 0;
    pix_in_win   = 0;
    win_in_cycle = 0;

    // Each cycle of fifteen windows reads only grid entries written in that
    // same cycle, so the typed means hold whatever came before.
    //  - all channels at full scale: 8 * 25 + 51
    //  - all channels at zero
    //  - channel zero full, channel one zero, channel two 128: checks that
    //    channel zero lands in mean_chan_low (8 * 12 + 25 = 121 for 128)
    //  - scattered windows, checked by prediction
    dir_tab = '{
      '{WIN_FLAT,    24'hFFFFFF, 5'd12, 1'b0, 24'h000000},
      '{WIN_FLAT,    24'hFFFFFF, 5'd3,  1'b1, 24'hFBFBFB},
      '{WIN_FLAT,    24'h000000, 5'd15, 1'b1, 24'h000000},
      '{WIN_FLAT,    24'h8000FF, 5'd15, 1'b1, 24'hFB0079},
      '{WIN_SCATTER, 24'h000000, 5'd15, 1'b0, 24'h000000},
      '{WIN_SCATTER, 24'h3A7FC5, 5'd15, 1'b0, 24'h000000}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table, no idling on either side.
    foreach (dir_tab[i]) begin
      typed_on   = dir_tab[i].typed;
      typed_mean = dir_tab[i].want;
      for (int w = 0; w < dir_tab[i].n_win; w++)
        send_window(dir_tab[i].kind, dir_tab[i].base, w);
    end
    typed_on = 1'b0;

    // Random windows, whole cycles of fifteen per phase.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct  = 32'(IDLE_PCT[ph]);
      stall_pct = 32'(STALL_PCT[ph]);
      for (int w = 0; w < CYCLES_PER_PHASE * GRID_CELLS; w++) begin
        r    = $urandom;
        base = r[23:0];
        r    = $urandom_range(99);
        if (r < 45)      kind = WIN_NOISE;
        else if (r < 65) kind = WIN_CLUSTER;
        else if (r < 78) kind = WIN_RAILS;
        else if (r < 90) kind = WIN_SCATTER;
        else             kind = WIN_FLAT;
        send_window(kind, base, w);
      end
    end
    pixel_valid <= 1'b0;

    // Drain: wait for every predicted mean, then wait on so that strays show.
    while (means_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("median_then_weighted_mean_rgb: match");
    end else begin
      $display("median_then_weighted_mean_rgb: mismatch");
    end
    $finish;
  end

endmodule
